// ===== hw/rtl/rlhc_pkg.sv =====
// Shared types and constants for the reference-counted LRU handle cache.
package rlhc_pkg;

	localparam int CMD_W          = 2;
	localparam int ID_W           = 6;
	localparam int STATUS_W       = 3;
	localparam int USE_W          = 16;
	localparam int LIMIT_W        = 7;
	localparam int DEF_ENTRIES    = 64;
	localparam int DEF_COUNT_BITS = 16;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_REGISTER = 2'd0,
		CMD_ACQUIRE  = 2'd1,
		CMD_RELEASE  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_UNKNOWN   = 3'd1,
		ST_NO_HOLD   = 3'd2,
		ST_HELD      = 3'd3,
		ST_SATURATED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_VICT
	} state_t;

	// input transaction: command in the low bits
	typedef struct packed {
		logic [ID_W-1:0]  entry_id;
		logic [CMD_W-1:0] command;
	} in_item_t;

	// output transaction: status in the low bits
	typedef struct packed {
		logic [4:0]          rsvd;
		logic [USE_W-1:0]    use_count;
		logic [ID_W-1:0]     close_id;
		logic                close_valid;
		logic                open_needed;
		logic [STATUS_W-1:0] status;
	} out_item_t;

	localparam int IN_W  = $bits(in_item_t);
	localparam int OUT_W = $bits(out_item_t);

	// controller to datapath
	typedef struct packed {
		logic cap;
		logic rd;
		logic vrd;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_victim;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== hw/rtl/refcounted_lru_handle_cache.sv =====
// Top level of the reference-counted LRU handle cache.
//
// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  s_tdata: command, entry_id
// m_*       out        m_tvalid / m_tready  m_tdata: status .. use_count
// cfg_*     in         cfg_we               cfg_wdata: open_limit
//
// One command at a time: after the input is accepted, a read state and an evaluate
// state follow, plus a victim state when an acquire closes the oldest idle entry
// (second read of the next-link memory); a new command is taken only after commit.
// The registered reads of the count and link memories set these steps.
// A held result stalls the commit until m_tready frees the output register.
// Reset clears flags and queue state at once; no clearing pass.
module refcounted_lru_handle_cache #(
	parameter int ENTRIES    = rlhc_pkg::DEF_ENTRIES,
	parameter int COUNT_BITS = rlhc_pkg::DEF_COUNT_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rlhc_pkg::LIMIT_W-1:0] cfg_wdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [rlhc_pkg::IN_W-1:0]    s_tdata,   // command, entry_id
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [rlhc_pkg::OUT_W-1:0]   m_tdata    // status, open_needed, close_valid,
	                                                // close_id, use_count, zero pad
);

	rlhc_pkg::dp_cmd_t  cmd;
	rlhc_pkg::dp_stat_t stat;

	rlhc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rlhc_dp #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== hw/rtl/rlhc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rlhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

// ===== hw/rtl/rlhc_ctrl.sv =====
// Command sequencer for the handle cache: read, evaluate, optional victim read, commit.
module rlhc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  rlhc_pkg::dp_stat_t stat,
	output rlhc_pkg::dp_cmd_t  cmd
);

	rlhc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlhc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rlhc_pkg::S_IDLE: begin
				if (s_tvalid) state_d = rlhc_pkg::S_READ;
			end
			rlhc_pkg::S_READ: begin
				state_d = rlhc_pkg::S_EVAL;
			end
			rlhc_pkg::S_EVAL: begin
				if (stat.need_victim) state_d = rlhc_pkg::S_VICT;
				else if (stat.out_free) state_d = rlhc_pkg::S_IDLE;
			end
			rlhc_pkg::S_VICT: begin
				if (stat.out_free) state_d = rlhc_pkg::S_IDLE;
			end
			default: state_d = rlhc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			rlhc_pkg::S_IDLE: begin
				s_tready = 1'b1;
				cmd.cap  = s_tvalid;
			end
			rlhc_pkg::S_READ: begin
				cmd.rd = 1'b1;
			end
			rlhc_pkg::S_EVAL: begin
				cmd.vrd    = stat.need_victim;
				cmd.commit = !stat.need_victim && stat.out_free;
			end
			rlhc_pkg::S_VICT: begin
				cmd.commit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/rlhc_dp.sv =====
// Datapath: entry flags, use-count and queue-link memories, queue and open bookkeeping.
module rlhc_dp #(
	parameter int ENTRIES    = rlhc_pkg::DEF_ENTRIES,
	parameter int COUNT_BITS = rlhc_pkg::DEF_COUNT_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rlhc_pkg::LIMIT_W-1:0]   cfg_wdata,
	input  logic [rlhc_pkg::IN_W-1:0]      s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rlhc_pkg::OUT_W-1:0]     m_tdata,
	input  rlhc_pkg::dp_cmd_t              cmd,
	output rlhc_pkg::dp_stat_t             stat
);

	localparam int IW   = $clog2(ENTRIES);
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int CB   = COUNT_BITS;
	localparam int CMPW = (CW > rlhc_pkg::LIMIT_W) ? CW : rlhc_pkg::LIMIT_W;
	localparam logic [CW-1:0] OPEN_MAX = CW'(ENTRIES);

	rlhc_pkg::in_item_t             item_q;
	logic [rlhc_pkg::LIMIT_W-1:0]   limit_q;
	logic [ENTRIES-1:0]             valid_q, queued_q;
	logic [IW-1:0]                  head_q, tail_q;
	logic [CW-1:0]                  qlen_q, open_q;
	logic                           out_valid_q;
	rlhc_pkg::out_item_t            out_q, out_d;

	logic [IW+rlhc_pkg::ID_W-1:0]   id_ext;
	logic [IW-1:0]                  e, rm_e, clid;
	logic                           in_range, known, isq, cnt_zero, cnt_sat, qne, open_ge, open_le;
	logic [CB-1:0]                  cnt_rd, cnt_cur, cnt_res, cnt_wd;
	logic [IW-1:0]                  next_rd, prev_rd;
	rlhc_pkg::status_t              st;
	logic                           opn, clv, cnt_we, set_valid;
	logic                           do_rm, rm_victim, do_push, do_dec, do_inc;
	logic [IW-1:0]                  head_d, tail_d;
	logic [CW-1:0]                  qlen_d, open_1, open_d;
	logic                           q_clr, next_we, prev_we;
	logic [IW-1:0]                  next_wa, next_wd, prev_wa, prev_wd, next_ra;
	logic [CB+rlhc_pkg::USE_W-1:0]  cnt_ext;
	logic [IW+rlhc_pkg::ID_W-1:0]   clid_ext;

	assign id_ext   = (IW + rlhc_pkg::ID_W)'(item_q.entry_id);
	assign e        = id_ext[IW-1:0];
	assign in_range = int'(item_q.entry_id) < ENTRIES;
	assign known    = in_range && valid_q[e];
	assign isq      = queued_q[e];
	assign cnt_cur  = valid_q[e] ? cnt_rd : '0;
	assign cnt_zero = (cnt_cur == '0);
	assign cnt_sat  = &cnt_cur;
	assign qne      = (qlen_q != '0);
	assign open_ge  = CMPW'(open_q) >= CMPW'(limit_q);
	assign open_le  = CMPW'(open_q) <= CMPW'(limit_q);

	assign stat.need_victim = (rlhc_pkg::cmd_t'(item_q.command) == rlhc_pkg::CMD_ACQUIRE)
		&& known && cnt_zero && !isq && open_ge && qne;
	assign stat.out_free    = !out_valid_q || m_tready;

	// memories
	assign next_ra = cmd.vrd ? head_q : e;

	rlhc_ram #(.WIDTH(CB), .DEPTH(ENTRIES)) u_cnt_ram (
		.clk   (clk),
		.we    (cmd.commit && cnt_we),
		.waddr (e),
		.wdata (cnt_wd),
		.re    (cmd.rd),
		.raddr (e),
		.rdata (cnt_rd)
	);

	rlhc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_next_ram (
		.clk   (clk),
		.we    (cmd.commit && next_we),
		.waddr (next_wa),
		.wdata (next_wd),
		.re    (cmd.rd || cmd.vrd),
		.raddr (next_ra),
		.rdata (next_rd)
	);

	rlhc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_prev_ram (
		.clk   (clk),
		.we    (cmd.commit && prev_we),
		.waddr (prev_wa),
		.wdata (prev_wd),
		.re    (cmd.rd),
		.raddr (e),
		.rdata (prev_rd)
	);

	// command decision
	always_comb begin
		st        = rlhc_pkg::ST_OK;
		opn       = 1'b0;
		clv       = 1'b0;
		clid      = '0;
		cnt_res   = '0;
		cnt_we    = 1'b0;
		cnt_wd    = '0;
		set_valid = 1'b0;
		do_rm     = 1'b0;
		rm_victim = 1'b0;
		do_push   = 1'b0;
		do_dec    = 1'b0;
		do_inc    = 1'b0;
		unique case (rlhc_pkg::cmd_t'(item_q.command))
			rlhc_pkg::CMD_REGISTER: begin
				if (!in_range) begin
					st = rlhc_pkg::ST_UNKNOWN;
				end else if (!cnt_zero) begin
					st      = rlhc_pkg::ST_HELD;
					cnt_res = cnt_cur;
				end else begin
					if (isq) begin
						do_rm  = 1'b1;
						do_dec = 1'b1;
						clv    = 1'b1;
						clid   = e;
					end
					set_valid = 1'b1;
					cnt_we    = 1'b1;
				end
			end
			rlhc_pkg::CMD_ACQUIRE: begin
				if (!known) begin
					st = rlhc_pkg::ST_UNKNOWN;
				end else if (!cnt_zero) begin
					if (cnt_sat) begin
						st      = rlhc_pkg::ST_SATURATED;
						cnt_res = cnt_cur;
					end else begin
						cnt_we  = 1'b1;
						cnt_wd  = cnt_cur + CB'(1);
						cnt_res = cnt_cur + CB'(1);
					end
				end else if (isq) begin
					do_rm   = 1'b1;
					cnt_we  = 1'b1;
					cnt_wd  = CB'(1);
					cnt_res = CB'(1);
				end else begin
					if (open_ge && qne) begin
						do_rm     = 1'b1;
						rm_victim = 1'b1;
						do_dec    = 1'b1;
						clv       = 1'b1;
						clid      = head_q;
					end
					do_inc  = 1'b1;
					opn     = 1'b1;
					cnt_we  = 1'b1;
					cnt_wd  = CB'(1);
					cnt_res = CB'(1);
				end
			end
			rlhc_pkg::CMD_RELEASE: begin
				if (!known) begin
					st = rlhc_pkg::ST_UNKNOWN;
				end else if (cnt_zero) begin
					st = rlhc_pkg::ST_NO_HOLD;
				end else begin
					cnt_we  = 1'b1;
					cnt_wd  = cnt_cur - CB'(1);
					cnt_res = cnt_cur - CB'(1);
					if (cnt_cur == CB'(1)) begin
						if (open_le) begin
							do_push = 1'b1;
						end else begin
							do_dec = 1'b1;
							clv    = 1'b1;
							clid   = e;
						end
					end
				end
			end
			default: begin
				if (known) cnt_res = cnt_cur;
			end
		endcase
	end

	// idle queue update
	assign rm_e = rm_victim ? head_q : e;

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		qlen_d  = qlen_q;
		q_clr   = 1'b0;
		next_we = 1'b0;
		next_wa = '0;
		next_wd = '0;
		prev_we = 1'b0;
		prev_wa = '0;
		prev_wd = '0;
		if (do_rm && qne) begin
			q_clr  = 1'b1;
			qlen_d = qlen_q - CW'(1);
			if (qlen_q == CW'(1)) begin
				head_d = '0;
				tail_d = '0;
			end else if (rm_e == head_q) begin
				head_d = next_rd;
			end else if (rm_e == tail_q) begin
				tail_d = prev_rd;
			end else begin
				next_we = 1'b1;
				next_wa = prev_rd;
				next_wd = next_rd;
				prev_we = 1'b1;
				prev_wa = next_rd;
				prev_wd = prev_rd;
			end
		end else if (do_push) begin
			if (!qne) begin
				head_d = e;
			end else begin
				next_we = 1'b1;
				next_wa = tail_q;
				next_wd = e;
				prev_we = 1'b1;
				prev_wa = e;
				prev_wd = tail_q;
			end
			tail_d = e;
			qlen_d = qlen_q + CW'(1);
		end
	end

	// close happens before a new open
	assign open_1 = (do_dec && open_q != '0) ? open_q - CW'(1) : open_q;
	assign open_d = (do_inc && open_1 != OPEN_MAX) ? open_1 + CW'(1) : open_1;

	assign cnt_ext  = (CB + rlhc_pkg::USE_W)'(cnt_res);
	assign clid_ext = (IW + rlhc_pkg::ID_W)'(clid);

	always_comb begin
		out_d             = '0;
		out_d.status      = st;
		out_d.open_needed = opn;
		out_d.close_valid = clv;
		out_d.close_id    = clid_ext[rlhc_pkg::ID_W-1:0];
		out_d.use_count   = cnt_ext[rlhc_pkg::USE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= rlhc_pkg::LIMIT_RESET;
			valid_q     <= '0;
			queued_q    <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			qlen_q      <= '0;
			open_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (cmd.commit) begin
				if (set_valid) valid_q[e] <= 1'b1;
				if (q_clr) queued_q[rm_e] <= 1'b0;
				if (do_push) queued_q[e] <= 1'b1;
				head_q      <= head_d;
				tail_q      <= tail_d;
				qlen_q      <= qlen_d;
				open_q      <= open_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) item_q <= s_tdata;
		if (cmd.commit) out_q <= out_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

// ===== hw/rtl/rlhc_chk.sv =====
// Port-level checker for the handle cache, bound to the top level.
module rlhc_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [rlhc_pkg::OUT_W-1:0] m_tdata
);

	rlhc_pkg::out_item_t o;
	assign o = m_tdata;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction taken while one is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> o.status <= rlhc_pkg::ST_SATURATED)
		else $error("status code out of range");

	a_close_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !o.close_valid |-> o.close_id == '0)
		else $error("close_id set without close_valid");

	a_open_count_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && o.open_needed |->
			o.status == rlhc_pkg::ST_OK && o.use_count == rlhc_pkg::USE_W'(1))
		else $error("new open without a fresh single hold");

endmodule

bind refcounted_lru_handle_cache rlhc_chk u_rlhc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
